@@ design/assert_macros.svh @@
// Assertion macros used by the cipher top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante -> cons");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante => cons");

`endif

@@ design/cmbc_pkg.sv @@
// Types, register indexes and the odd-byte inverse table of the byte cipher.
package cmbc_pkg;

   typedef logic [7:0] byte_type;
   typedef byte_type inv_table_type [128];

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_MODE_DECRYPT = 2'd0,
      CSR_INITIAL_KEY  = 2'd1,
      CSR_OFFSET_ALPHA = 2'd2
   } csr_index_type;

   localparam byte_type INITIAL_KEY_RESET  = 8'd1;
   localparam byte_type OFFSET_ALPHA_RESET = 8'd0;

   // Inverse mod 256 of the odd byte 2*i+1, two Newton steps from x itself
   function automatic inv_table_type build_inv_table();
      inv_table_type tbl;
      logic [15:0]   x;
      logic [15:0]   y;
      logic [15:0]   t;
      for (int i = 0; i < 128; i++) begin
         x = 16'(2 * i + 1);
         y = x;
         t = 16'(8'(x * y));
         y = 16'(8'(y * 16'(16'd2 - t)));
         t = 16'(8'(x * y));
         y = 16'(8'(y * 16'(16'd2 - t)));
         tbl[i] = y[7:0];
      end
      return tbl;
   endfunction

   localparam inv_table_type INV_TABLE = build_inv_table();

endpackage

@@ design/chained_multiplicative_byte_cipher_unit.sv @@
// Top level of the chained multiplicative byte cipher.
//
// Usage:
//  - Input beats (req_*) carry one byte plus first/last flags; a beat is taken
//    when req_valid is high and req_stall is low.
//  - Result beats (rsp_*) carry the transformed byte, the chain key after it and
//    the last flag; a beat is taken when rsp_valid is high and rsp_stall is low.
//  - The csr_* port writes mode, initial key and offset; write only while idle.
//    Writes to unused indexes are dropped.
//  - A beat passes one input register, then the inverse lookup, one 8x8 multiply
//    and one add (encrypt) or one subtract and one 8x8 multiply (decrypt) into
//    the result register. Throughput is one byte per cycle while the receiver
//    does not stall; the chain key register is updated in the same cycle the
//    byte moves to the result register, so the next byte sees it at once.
//  - When the receiver stalls, the result register holds and the input
//    register fills; req_stall rises once both are occupied.
//  - Reset clears both stages, reloads the register defaults (encrypt,
//    initial key 1, offset 0) and sets the chain key to 0.
module chained_multiplicative_byte_cipher_unit
   import cmbc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_in,
   input  logic       req_first_byte,
   input  logic       req_last_byte,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_out,
   output logic [7:0] rsp_key_after,
   output logic       rsp_is_last,
   // configuration
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

`include "assert_macros.svh"

   // Configuration registers
   logic     mode_decrypt_ff;
   byte_type initial_key_ff;
   byte_type offset_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_decrypt_ff <= 1'b0;
         initial_key_ff  <= INITIAL_KEY_RESET;
         offset_alpha_ff <= OFFSET_ALPHA_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE_DECRYPT: mode_decrypt_ff <= csr_wdata[0];
            CSR_INITIAL_KEY:  initial_key_ff  <= csr_wdata;
            CSR_OFFSET_ALPHA: offset_alpha_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipeline control
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic s1_advance;
   logic s1_load;

   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign s1_load    = req_valid && !req_stall;

   // Input register
   byte_type s1_data_ff;
   logic     s1_first_ff;
   logic     s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_data_ff  <= req_data_in;
         s1_first_ff <= req_first_byte;
         s1_last_ff  <= req_last_byte;
      end
   end

   // Cipher datapath
   byte_type chain_key_ff;
   byte_type key;
   byte_type inv_key;
   byte_type mul_a;
   byte_type mul_b;
   byte_type product;
   byte_type result_in;
   byte_type plain;
   byte_type key_after_in;

   always_comb begin
      key     = s1_first_ff ? initial_key_ff : chain_key_ff;
      inv_key = INV_TABLE[key[7:1]];
      if (mode_decrypt_ff) begin
         mul_a = s1_data_ff - offset_alpha_ff;
         mul_b = key;
      end else begin
         mul_a = s1_data_ff;
         mul_b = inv_key;
      end
      product = 8'(mul_a * mul_b);
      if (mode_decrypt_ff) begin
         result_in = product;
         plain     = product;
      end else begin
         result_in = product + offset_alpha_ff;
         plain     = s1_data_ff;
      end
      key_after_in = {plain[6:0], 1'b1};
   end

   // Chain key follows each byte as it leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_key_ff <= '0;
      end else if (s1_valid_ff && s1_advance) begin
         chain_key_ff <= key_after_in;
      end
   end

   // Result register
   byte_type rsp_data_ff;
   byte_type rsp_key_ff;
   logic     rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_advance) begin
         rsp_data_ff <= result_in;
         rsp_key_ff  <= key_after_in;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_out  = rsp_data_ff;
   assign rsp_key_after = rsp_key_ff;
   assign rsp_is_last   = rsp_last_ff;

   // Checks
   `ASSERT_NEXT(a_move_fills_rsp, clock, reset, s1_valid_ff && s1_advance, rsp_valid_ff)
   `ASSERT_NEXT(a_chain_key_odd, clock, reset, s1_valid_ff && s1_advance, chain_key_ff[0])
   `ASSERT_IMPL(a_rsp_key_odd, clock, reset, rsp_valid_ff, rsp_key_ff[0])

endmodule

@@ tb/cmbc_result_checker.sv @@
// Scoreboard for the byte cipher: predicts every result beat and compares it field by field.
`timescale 1ns / 100ps

module cmbc_result_checker
   import cmbc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_data_in,
   input  logic       req_first_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_data_out,
   input  logic [7:0] rsp_key_after,
   input  logic       rsp_is_last,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output int         mismatch_count,
   output int         pending_count
);

   typedef struct packed {
      byte_type data_out;
      byte_type key_after;
      logic     is_last;
   } cipher_beat_type;

   byte_type        odd_byte_inverse [128];
   logic            decrypt_mode;
   byte_type        start_key;
   byte_type        alpha;
   byte_type        chain_key;
   cipher_beat_type cipher_beats_due [$];

   // Inverse of each odd byte, found by trying every odd candidate
   initial begin
      for (int i = 0; i < 128; i++) begin
         odd_byte_inverse[i] = 8'd0;
         for (int y = 1; y < 256; y += 2) begin
            if (8'((2 * i + 1) * y) == 8'd1) odd_byte_inverse[i] = 8'(y);
         end
      end
   end

   // Expected beat for one input byte under the current key chain and registers
   function automatic cipher_beat_type cipher_byte_result(input byte_type din, input logic first,
                                                          input logic last);
      byte_type        key;
      byte_type        plain;
      cipher_beat_type beat;
      key = first ? start_key : chain_key;
      if (decrypt_mode) begin
         // even keys go in unchanged
         beat.data_out = (din - alpha) * key;
         plain = beat.data_out;
      end else begin
         // even key takes the inverse of key | 1
         beat.data_out = din * odd_byte_inverse[key[7:1]] + alpha;
         plain = din;
      end
      beat.key_after = {plain[6:0], 1'b1};
      beat.is_last = last;
      return beat;
   endfunction

   always @(posedge clock) begin
      cipher_beat_type want;
      cipher_beat_type got;
      if (reset) begin
         decrypt_mode = 1'b0;
         start_key = INITIAL_KEY_RESET;
         alpha = OFFSET_ALPHA_RESET;
         chain_key = 8'd0;
         cipher_beats_due.delete();
      end else begin
         // register writes; unused index is dropped
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_MODE_DECRYPT: decrypt_mode = csr_wdata[0];
               CSR_INITIAL_KEY:  start_key = csr_wdata;
               CSR_OFFSET_ALPHA: alpha = csr_wdata;
               default: ;
            endcase
         end
         // result beat against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_data_out, rsp_key_after, rsp_is_last};
            if (cipher_beats_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected beat data_out %02h key_after %02h is_last %0b",
                           $realtime, got.data_out, got.key_after, got.is_last);
            end else begin
               want = cipher_beats_due.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: mismatch data_out exp %02h got %02h, ",
                               "key_after exp %02h got %02h, is_last exp %0b got %0b"},
                              $realtime, want.data_out, got.data_out, want.key_after,
                              got.key_after, want.is_last, got.is_last);
               end
            end
         end
         // input beat: predict and advance the chain
         if (req_valid && !req_stall) begin
            want = cipher_byte_result(req_data_in, req_first_byte, req_last_byte);
            chain_key = want.key_after;
            cipher_beats_due.push_back(want);
         end
      end
      pending_count <= cipher_beats_due.size();
   end

endmodule

@@ tb/tb_chained_multiplicative_byte_cipher_unit.sv @@
// Testbench top for the byte cipher: clock, reset, stimulus, register writes and the verdict.
`timescale 1ns / 100ps

module tb_chained_multiplicative_byte_cipher_unit
   import cmbc_pkg::*;
();

   localparam logic [1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int         BYTES_PER_SETTING = 150;
   localparam int         RANDOM_SETTINGS = 13;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_in = 8'd0;
   logic       req_first_byte = 1'b0;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_data_out;
   logic [7:0] rsp_key_after;
   logic       rsp_is_last;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_index = 2'd0;
   logic [7:0] csr_wdata = 8'd0;

   int send_idle_pct = 13;
   int recv_stall_pct = 51;
   int mismatch_count;
   int pending_count;

   chained_multiplicative_byte_cipher_unit uut (
      .clock, .reset,
      .req_valid, .req_stall, .req_data_in, .req_first_byte, .req_last_byte,
      .rsp_valid, .rsp_stall, .rsp_data_out, .rsp_key_after, .rsp_is_last,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   cmbc_result_checker checker_i (
      .clock, .reset,
      .req_valid, .req_stall, .req_data_in, .req_first_byte, .req_last_byte,
      .rsp_valid, .rsp_stall, .rsp_data_out, .rsp_key_after, .rsp_is_last,
      .csr_wr_en, .csr_index, .csr_wdata,
      .mismatch_count, .pending_count
   );

   always #5 clock = ~clock;

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // run limit
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // one input beat, with random idle cycles ahead of it; returns at a falling edge
   task automatic send_byte(input byte_type data, input logic first, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_in <= data;
      req_first_byte <= first;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input byte_type value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // stop sending and let every predicted beat come out
   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int count;
      int len;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset registers; first beat runs on the zero chain key
      send_byte(8'h5A, 1'b0, 1'b0);
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h80, 1'b0, 1'b1);
      // chain runs on past a last beat
      send_byte(8'h01, 1'b0, 1'b0);
      send_byte(8'h7F, 1'b1, 1'b1);

      // encrypt with an even start key and full offset; upper mode bits ignored
      quiesce();
      write_csr(CSR_MODE_DECRYPT, 8'hFE);
      write_csr(CSR_INITIAL_KEY, 8'hAA);
      write_csr(CSR_OFFSET_ALPHA, 8'hFF);
      write_csr(CSR_UNUSED_INDEX, 8'hFF);
      send_byte(8'hFF, 1'b1, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h33, 1'b0, 1'b1);

      // decrypt with a zero key
      quiesce();
      write_csr(CSR_MODE_DECRYPT, 8'h01);
      write_csr(CSR_INITIAL_KEY, 8'h00);
      write_csr(CSR_OFFSET_ALPHA, 8'h00);
      send_byte(8'h10, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);

      // decrypt with an even key, used as given
      quiesce();
      write_csr(CSR_INITIAL_KEY, 8'hFE);
      write_csr(CSR_OFFSET_ALPHA, 8'hFF);
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h80, 1'b0, 1'b0);
      send_byte(8'h01, 1'b0, 1'b1);

      quiesce();
      write_csr(CSR_INITIAL_KEY, 8'hFF);
      write_csr(CSR_OFFSET_ALPHA, 8'h80);
      send_byte(8'hFF, 1'b1, 1'b1);
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hC3, 1'b0, 1'b0);

      // random messages under changing settings and idle patterns
      for (int s = 0; s < RANDOM_SETTINGS; s++) begin
         quiesce();
         if (s == 5) begin
            send_idle_pct = 51;
            recv_stall_pct = 13;
         end
         if (s == 9) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         write_csr(CSR_MODE_DECRYPT, {7'($urandom), s[0]});
         case (s % 4)
            0: begin
               write_csr(CSR_INITIAL_KEY, 8'h00);
               write_csr(CSR_OFFSET_ALPHA, 8'hFF);
            end
            1: begin
               write_csr(CSR_INITIAL_KEY, 8'hFF);
               write_csr(CSR_OFFSET_ALPHA, 8'h00);
            end
            default: begin
               write_csr(CSR_INITIAL_KEY, 8'($urandom));
               write_csr(CSR_OFFSET_ALPHA, 8'($urandom));
            end
         endcase
         if ($urandom_range(1) == 1) write_csr(CSR_UNUSED_INDEX, 8'($urandom));

         count = 0;
         while (count < BYTES_PER_SETTING) begin
            if ($urandom_range(9) == 0) begin
               // stray beat with random flags
               send_byte(8'($urandom), 1'($urandom), 1'($urandom));
               count++;
            end else begin
               len = $urandom_range(1, 12);
               for (int k = 0; k < len; k++)
                  send_byte(8'($urandom), k == 0, k == len - 1);
               count += len;
            end
         end
      end

      quiesce();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/cmbc_pkg.sv
design/chained_multiplicative_byte_cipher_unit.sv
tb/cmbc_result_checker.sv
tb/tb_chained_multiplicative_byte_cipher_unit.sv
